// ===== design/urtb_pkg.sv =====
// Shared types and constants for the UART receive/transmit ring buffers.
package urtb_pkg;

	localparam int unsigned RING_DEPTH_DEF = 256;

	typedef enum logic [1:0] {
		OP_HOST_PUT = 2'd0,
		OP_HOST_GET = 2'd1,
		OP_UART_RX  = 2'd2,
		OP_UART_TXR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-ring control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
	} ring_cmd_t;

	// per-ring state toward the sequencer
	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

endpackage

// ===== design/urtb_ring.sv =====
// One byte ring: storage memory plus read and write pointers, one slot kept empty.
module urtb_ring #(
	parameter int unsigned RING_DEPTH = urtb_pkg::RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  urtb_pkg::ring_cmd_t  cmd,
	input  logic [7:0]           wr_data,
	output urtb_pkg::ring_stat_t stat,
	output logic [7:0]           rd_data
);

	localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

	logic [7:0]       mem [RING_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_next;
	logic [PTR_W-1:0] wr_next;
	logic [7:0]       rd_data_q;

	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;

	assign stat.full  = (wr_next == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (cmd.push && !stat.full)
				wr_ptr_q <= wr_next;
			if (cmd.pop && !stat.empty)
				rd_ptr_q <= rd_next;
		end
	end

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push && !stat.full)
			mem[wr_ptr_q] <= wr_data;
		if (cmd.pop && !stat.empty)
			rd_data_q <= mem[rd_ptr_q];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/uart_rx_tx_ring_buffers.sv =====
// Top level: UART receive and transmit ring buffers with transmit interrupt enable.
//
// An item (operation, data_byte) is taken at each clock edge where start is high and
// busy is low; busy is never raised, so one item can enter every cycle. Its result
// appears on the cycle after acceptance: done pulses for one cycle with status,
// out_byte, send_valid and tx_irq_enabled. The result is registered, out_byte in
// the registered read port of the ring memories; the pointers and the
// interrupt enable update at the accepting edge, so back-to-back items see each
// other's effects. The receiver cannot stall, so every done pulse must be captured.
// Each ring holds at most RING_DEPTH-1 bytes. Host put (0) queues on the transmit
// ring and turns the transmit interrupt on; status 1 when full. Host get (1) pops
// the receive ring; status 2 when empty. UART received byte (2) stores into the
// receive ring or drops it with status 1. Transmit ready (3) pops a byte with
// send_valid high, or reports status 2 and turns the transmit interrupt off.
// out_byte is zero unless a byte was popped. Ring contents are not cleared at
// reset; no reset pass is needed since only written slots are ever read.
module uart_rx_tx_ring_buffers #(
	parameter int unsigned RING_DEPTH = urtb_pkg::RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] out_byte,
	output logic       send_valid,
	output logic       tx_irq_enabled
);

	urtb_pkg::op_t        op;
	urtb_pkg::ring_cmd_t  rx_cmd, tx_cmd;
	urtb_pkg::ring_stat_t rx_stat, tx_stat;
	urtb_pkg::status_t    st_d;
	logic [7:0]           rx_rd_data, tx_rd_data;
	logic                 accept;
	logic                 irq_d;

	logic                 valid_s1;
	urtb_pkg::status_t    status_s1;
	logic                 pop_rx_s1;
	logic                 pop_tx_s1;
	logic                 irq_s1;
	logic                 tx_irq_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op     = urtb_pkg::op_t'(operation);

	// decode one item against the current ring state
	always_comb begin
		rx_cmd = '0;
		tx_cmd = '0;
		st_d   = urtb_pkg::ST_OK;
		irq_d  = tx_irq_q;
		case (op)
			urtb_pkg::OP_HOST_PUT: begin
				tx_cmd.push = accept;
				if (tx_stat.full)
					st_d = urtb_pkg::ST_FULL;
				else
					irq_d = 1'b1;
			end
			urtb_pkg::OP_HOST_GET: begin
				rx_cmd.pop = accept;
				if (rx_stat.empty)
					st_d = urtb_pkg::ST_EMPTY;
			end
			urtb_pkg::OP_UART_RX: begin
				rx_cmd.push = accept;
				if (rx_stat.full)
					st_d = urtb_pkg::ST_FULL;
			end
			urtb_pkg::OP_UART_TXR: begin
				tx_cmd.pop = accept;
				if (tx_stat.empty) begin
					st_d  = urtb_pkg::ST_EMPTY;
					irq_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	urtb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rx_cmd),
		.wr_data (data_byte),
		.stat    (rx_stat),
		.rd_data (rx_rd_data)
	);

	urtb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tx_cmd),
		.wr_data (data_byte),
		.stat    (tx_stat),
		.rd_data (tx_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			tx_irq_q  <= 1'b0;
			pop_rx_s1 <= 1'b0;
			pop_tx_s1 <= 1'b0;
		end else begin
			valid_s1  <= accept;
			pop_rx_s1 <= rx_cmd.pop && !rx_stat.empty;
			pop_tx_s1 <= tx_cmd.pop && !tx_stat.empty;
			if (accept)
				tx_irq_q <= irq_d;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_d;
			irq_s1    <= irq_d;
		end
	end

	assign done           = valid_s1;
	assign status         = status_s1;
	assign send_valid     = pop_tx_s1;
	assign tx_irq_enabled = irq_s1;
	assign out_byte       = pop_rx_s1 ? rx_rd_data :
				pop_tx_s1 ? tx_rd_data : 8'd0;

endmodule

// ===== design/urtb_checker.sv =====
// Port-level checks for the UART ring buffers, bound to the top level.
module urtb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] out_byte,
	input logic       send_valid,
	input logic       tx_irq_enabled
);

	// every accepted item yields exactly one result, in the following cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without accepted item");

	// a byte sent to the uart leaves the ring non-empty beforehand: status ok
	a_send_ok: assert property (@(posedge clk) disable iff (!arst_n)
		send_valid |-> (done && status == urtb_pkg::ST_OK))
		else $error("send strobe outside an ok result");

	// nothing popped on a refused or empty result
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != urtb_pkg::ST_OK) |-> (out_byte == 8'd0 && !send_valid))
		else $error("byte shown on failed item");

	// an empty report with the interrupt on never comes with a send strobe
	a_irq_off: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == urtb_pkg::ST_EMPTY && tx_irq_enabled) |-> !send_valid)
		else $error("send with empty status");

endmodule

bind uart_rx_tx_ring_buffers urtb_checker u_urtb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.out_byte       (out_byte),
	.send_valid     (send_valid),
	.tx_irq_enabled (tx_irq_enabled)
);

// ===== tb/sv/tb.sv =====
// Testbench for the UART ring buffers: directed table, then random traffic against a predictor.
`timescale 1ns / 100ps

module tb;
	import urtb_pkg::*;

	localparam int RING_SLOTS  = RING_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1850;
	// ~1900 items with short gaps: far below this
	localparam int CYCLE_LIMIT = 200000;

	// one result as seen on the result ports
	typedef struct packed {
		status_t    st;
		logic [7:0] obyte;
		logic       send;
		logic       irq;
	} ring_reply_t;

	// directed row: item plus an optional typed-in reply
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic        pinned;
		ring_reply_t reply;
	} dir_row_t;

	// typed-in reply travelling with an item until it is accepted
	typedef struct packed {
		logic        pinned;
		ring_reply_t reply;
	} pinned_reply_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic       done;
	logic [1:0] status;
	logic [7:0] out_byte;
	logic       send_valid;
	logic       tx_irq_enabled;

	uart_rx_tx_ring_buffers #(
		.RING_DEPTH(RING_SLOTS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.data_byte     (data_byte),
		.done          (done),
		.status        (status),
		.out_byte      (out_byte),
		.send_valid    (send_valid),
		.tx_irq_enabled(tx_irq_enabled)
	);

	// ---------------------------------------------------------------
	// Shadow copy of both rings and the transmit interrupt enable
	// ---------------------------------------------------------------
	logic [7:0] rx_shadow [RING_SLOTS];
	logic [7:0] tx_shadow [RING_SLOTS];
	int         rx_rd, rx_wr, tx_rd, tx_wr;
	logic       tx_irq_shadow;

	ring_reply_t   expected_replies [$];
	pinned_reply_t pinned_replies [$];
	dir_row_t      dir_rows [$];

	int fail_count;
	int reply_count;
	int cycle_count;
	int burst_left;
	bit steady;

	function automatic int ring_next(input int p);
		return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
	endfunction

	// one ring step: updates the shadow state, returns the reply
	task automatic predict_ring_op(input op_t op, input logic [7:0] d, output ring_reply_t r);
		r.st    = ST_OK;
		r.obyte = 8'h00;
		r.send  = 1'b0;
		case (op)
			OP_HOST_PUT: begin
				// one slot stays empty, so full is wr+1 == rd
				if (ring_next(tx_wr) == tx_rd) begin
					r.st = ST_FULL;
				end else begin
					tx_shadow[tx_wr] = d;
					tx_wr = ring_next(tx_wr);
					tx_irq_shadow = 1'b1;
				end
			end
			OP_HOST_GET: begin
				if (rx_rd == rx_wr) begin
					r.st = ST_EMPTY;
				end else begin
					r.obyte = rx_shadow[rx_rd];
					rx_rd = ring_next(rx_rd);
				end
			end
			OP_UART_RX: begin
				if (ring_next(rx_wr) == rx_rd) begin
					r.st = ST_FULL;
				end else begin
					rx_shadow[rx_wr] = d;
					rx_wr = ring_next(rx_wr);
				end
			end
			default: begin
				// transmit ready is served even with the interrupt already off
				if (tx_rd == tx_wr) begin
					r.st = ST_EMPTY;
					tx_irq_shadow = 1'b0;
				end else begin
					r.obyte = tx_shadow[tx_rd];
					tx_rd = ring_next(tx_rd);
					r.send = 1'b1;
				end
			end
		endcase
		r.irq = tx_irq_shadow;
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got_v,
			input logic [7:0] want_v);
		fail_count++;
		$display("mismatch %s: got %h want %h (reply %0d)", what, got_v, want_v,
			reply_count);
	endtask

	// ---------------------------------------------------------------
	// Clock, watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: values read here are the ones before this edge's updates.
	// Check the strobe first, then log an item taken at this edge.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		ring_reply_t   want;
		pinned_reply_t pin;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("done with nothing pending", 8'h01, 8'h00);
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.st)
						report_mismatch("status", {6'd0, status}, {6'd0, want.st});
					if (out_byte !== want.obyte)
						report_mismatch("out_byte", out_byte, want.obyte);
					if (send_valid !== want.send)
						report_mismatch("send_valid", {7'd0, send_valid}, {7'd0, want.send});
					if (tx_irq_enabled !== want.irq)
						report_mismatch("tx_irq_enabled", {7'd0, tx_irq_enabled},
							{7'd0, want.irq});
				end
				reply_count++;
			end else if (done !== 1'b0) begin
				report_mismatch("done unknown", {7'd0, done}, 8'h00);
			end

			if (start === 1'b1 && busy === 1'b0) begin
				// predictor always runs so shadow state tracks pinned rows too
				predict_ring_op(op_t'(operation), data_byte, want);
				if (pinned_replies.size() != 0) begin
					pin = pinned_replies.pop_front();
					if (pin.pinned)
						want = pin.reply;
				end
				expected_replies.push_back(want);
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver tasks, all called right after a rising edge
	// ---------------------------------------------------------------
	task automatic issue_item(input op_t op, input logic [7:0] d, input logic pinned,
			input ring_reply_t reply);
		pinned_reply_t pin;
		pin.pinned = pinned;
		pin.reply  = reply;
		pinned_replies.push_back(pin);
		start     <= 1'b1;
		operation <= op;
		data_byte <= d;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// idle with noise on the item lines; start low keeps it ignored
	task automatic idle_cycles(input int n);
		repeat (n) begin
			start     <= 1'b0;
			operation <= 2'($urandom_range(0, 3));
			data_byte <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
	endtask

	// bursts of random length, random gaps, none in steady stretches
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (!steady)
				idle_cycles($urandom_range(1, 7));
		end
		burst_left--;
	endtask

	// hold off until every pending reply has come back
	task automatic drain_replies();
		start <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic dir_row_t row(input op_t op, input logic [7:0] d, input logic pinned,
			input status_t st, input logic [7:0] ob, input logic sv, input logic irq);
		dir_row_t r;
		r.op           = op;
		r.data         = d;
		r.pinned       = pinned;
		r.reply.st     = st;
		r.reply.obyte  = ob;
		r.reply.send   = sv;
		r.reply.irq    = irq;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		ring_reply_t none;
		op_t         op;
		int          mode;
		int          seg_len;
		int          issued;
		int          pick;
		bit          mid_drain_done;

		start     = 1'b0;
		operation = 2'd0;
		data_byte = 8'd0;
		arst_n    = 1'b0;
		fail_count = 0;
		reply_count = 0;
		cycle_count = 0;
		burst_left = 0;
		steady = 1'b0;
		rx_rd = 0; rx_wr = 0; tx_rd = 0; tx_wr = 0;
		tx_irq_shadow = 1'b0;
		none = '0;

		// directed table; pinned rows carry the obvious reply
		// empty rings after reset, data ignored on get / transmit ready
		dir_rows.push_back(row(OP_HOST_GET, 8'hA5, 1, ST_EMPTY, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_TXR, 8'h5A, 1, ST_EMPTY, 8'h00, 0, 0));
		// puts turn the interrupt on
		dir_rows.push_back(row(OP_HOST_PUT, 8'h00, 1, ST_OK, 8'h00, 0, 1));
		dir_rows.push_back(row(OP_HOST_PUT, 8'hFF, 1, ST_OK, 8'h00, 0, 1));
		dir_rows.push_back(row(OP_HOST_PUT, 8'h81, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_TXR, 8'h3C, 1, ST_OK, 8'h00, 1, 1));
		dir_rows.push_back(row(OP_UART_TXR, 8'hC3, 1, ST_OK, 8'hFF, 1, 1));
		dir_rows.push_back(row(OP_UART_TXR, 8'h00, 0, ST_OK, 8'h00, 0, 0));
		// drained: interrupt goes off, then transmit ready with it already off
		dir_rows.push_back(row(OP_UART_TXR, 8'hFF, 1, ST_EMPTY, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_TXR, 8'h00, 1, ST_EMPTY, 8'h00, 0, 0));
		// receive side
		dir_rows.push_back(row(OP_UART_RX, 8'hFF, 1, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_RX, 8'h00, 1, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_RX, 8'h7E, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_HOST_GET, 8'h00, 1, ST_OK, 8'hFF, 0, 0));
		dir_rows.push_back(row(OP_HOST_GET, 8'hFF, 1, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_HOST_GET, 8'h5A, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_HOST_GET, 8'hA5, 1, ST_EMPTY, 8'h00, 0, 0));
		// mixed, predictor only
		dir_rows.push_back(row(OP_HOST_PUT, 8'h55, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_RX, 8'hAA, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_HOST_GET, 8'h0F, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_TXR, 8'hF0, 0, ST_OK, 8'h00, 0, 0));
		dir_rows.push_back(row(OP_UART_TXR, 8'h01, 0, ST_OK, 8'h00, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			pace_sender();
			issue_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].pinned,
				dir_rows[i].reply);
		end
		drain_replies();

		// random segments: fill and drain runs push both rings to full and empty
		issued = 0;
		mid_drain_done = 1'b0;
		while (issued < RANDOM_ITEMS) begin
			mode    = $urandom_range(0, 5);
			seg_len = $urandom_range(40, 320);
			steady  = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < seg_len && issued < RANDOM_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				op   = op_t'($urandom_range(0, 3));
				case (mode)
					1: if (pick < 94) op = OP_HOST_PUT;
					2: if (pick < 94) op = OP_UART_TXR;
					3: if (pick < 94) op = OP_UART_RX;
					4: if (pick < 94) op = OP_HOST_GET;
					5: if (pick < 94) op = (pick < 47) ? OP_HOST_PUT : OP_UART_RX;
					default: ;
				endcase
				pace_sender();
				issue_item(op, 8'($urandom_range(0, 255)), 1'b0, none);
				issued++;
			end
			if (!mid_drain_done && issued >= RANDOM_ITEMS / 2) begin
				drain_replies();
				mid_drain_done = 1'b1;
			end
		end

		drain_replies();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/urtb_pkg.sv
design/urtb_ring.sv
design/uart_rx_tx_ring_buffers.sv
design/urtb_checker.sv
tb/sv/tb.sv
